FILE: hdl/rcfq_pkg.sv
// Shared types, codes and defaults for the range-classified four-queue block.
package rcfq_pkg;

   localparam int DEPTH_DEFAULT      = 128;
   localparam int DATA_WIDTH_DEFAULT = 16;
   localparam int NUM_QUEUES         = 4;
   localparam int QUEUE_W            = 2;
   localparam int VALUE_W            = 16;
   localparam int CSR_INDEX_W        = 2;

   localparam logic signed [VALUE_W-1:0] FIRST_THRESHOLD_RESET  = 16'sd10;
   localparam logic signed [VALUE_W-1:0] SECOND_THRESHOLD_RESET = 16'sd20;
   localparam logic signed [VALUE_W-1:0] THIRD_THRESHOLD_RESET  = 16'sd30;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_ENQUEUED = 2'd0,
      STATUS_DEQUEUED = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THIRD_THRESHOLD  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_rsp;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

endpackage

FILE: hdl/rcfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rcfq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/rcfq_ctrl.sv
// Controller state machine: accept a request, execute it, hand off the response.
module rcfq_ctrl
   import rcfq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // The read data stays in the RAM output until the response register frees up.
            if (dp_status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/rcfq_dp.sv
// Datapath: thresholds, classifier, queue counters, queue storage and response register.
module rcfq_dp
   import rcfq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]     csr_wdata,
   input  logic                   req_op,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic [QUEUE_W-1:0]     req_pick,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          dp_status,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid_ff,
   output logic [1:0]             rsp_status_ff,
   output logic [QUEUE_W-1:0]     rsp_queue_ff,
   output logic [VALUE_W-1:0]     rsp_data_ff
);

   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH + 1);
   localparam int RAM_AW = AW + QUEUE_W;
   localparam int RAM_D  = NUM_QUEUES << AW;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic signed [VALUE_W-1:0] thr0_ff, thr1_ff, thr2_ff;
   logic [CW-1:0]             wcnt_ff [NUM_QUEUES];
   logic [CW-1:0]             rcnt_ff [NUM_QUEUES];

   op_type                    op_ff;
   logic [VALUE_W-1:0]        value_ff;
   logic [QUEUE_W-1:0]        pick_ff;
   status_type                status_ff;
   status_type                status_in;
   logic [QUEUE_W-1:0]        queue_in;
   logic [QUEUE_W-1:0]        queue_ff;

   logic                      full;
   logic                      empty;
   logic                      wr_en;
   logic                      rd_en;
   logic [RAM_AW-1:0]         wr_addr;
   logic [RAM_AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0]     rd_data_ff;
   logic signed [VALUE_W-1:0] value_s;

   // Threshold registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr0_ff <= FIRST_THRESHOLD_RESET;
         thr1_ff <= SECOND_THRESHOLD_RESET;
         thr2_ff <= THIRD_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_THRESHOLD:  thr0_ff <= csr_wdata;
            CSR_SECOND_THRESHOLD: thr1_ff <= csr_wdata;
            CSR_THIRD_THRESHOLD:  thr2_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
         pick_ff  <= req_pick;
      end
   end

   assign value_s = $signed(value_ff);

   always_comb begin
      if (op_ff == OP_DEQUEUE) begin
         queue_in = pick_ff;
      end else if (value_s < thr0_ff) begin
         queue_in = 2'd0;
      end else if (value_s < thr1_ff) begin
         queue_in = 2'd1;
      end else if (value_s < thr2_ff) begin
         queue_in = 2'd2;
      end else begin
         queue_in = 2'd3;
      end
   end

   assign full  = wcnt_ff[queue_in] >= DEPTH_C;
   assign empty = (rcnt_ff[queue_in] >= wcnt_ff[queue_in]) || (rcnt_ff[queue_in] >= DEPTH_C);

   always_comb begin
      if (op_ff == OP_ENQUEUE) begin
         status_in = full ? STATUS_FULL : STATUS_ENQUEUED;
      end else begin
         status_in = empty ? STATUS_EMPTY : STATUS_DEQUEUED;
      end
   end

   assign wr_en   = cmd.exec && (op_ff == OP_ENQUEUE) && !full;
   assign rd_en   = cmd.exec && (op_ff == OP_DEQUEUE) && !empty;
   assign wr_addr = {queue_in, wcnt_ff[queue_in][AW-1:0]};
   assign rd_addr = {queue_in, rcnt_ff[queue_in][AW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            wcnt_ff[i] <= '0;
            rcnt_ff[i] <= '0;
         end
      end else begin
         if (wr_en) begin
            wcnt_ff[queue_in] <= wcnt_ff[queue_in] + 1'b1;
         end
         if (rd_en) begin
            rcnt_ff[queue_in] <= rcnt_ff[queue_in] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         queue_ff  <= queue_in;
      end
   end

   rcfq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (RAM_D)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (DATA_WIDTH'(value_ff)),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data_ff)
   );

   // Response register; it frees when empty or when the receiver takes it.
   assign dp_status.rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_queue_ff  <= queue_ff;
         rsp_data_ff   <= (status_ff == STATUS_DEQUEUED) ? VALUE_W'(rd_data_ff) : '0;
      end
   end

`ifndef ASSERT_OFF
   a_no_wr_rd_same: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("queue store written and read in the same cycle");

   a_reads_behind_writes: assert property (@(posedge clock) disable iff (reset)
      (rcnt_ff[0] <= wcnt_ff[0]) && (rcnt_ff[1] <= wcnt_ff[1]) &&
      (rcnt_ff[2] <= wcnt_ff[2]) && (rcnt_ff[3] <= wcnt_ff[3]))
      else $error("read count passed write count");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> dp_status.rsp_free)
      else $error("response register overwritten while still pending");

   a_write_bumps_count: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (wcnt_ff[$past(queue_in)] == $past(wcnt_ff[queue_in]) + 1'b1))
      else $error("write count did not advance after a store");
`endif

endmodule

FILE: hdl/range_classified_four_queues.sv
// Top level of the range-classified four-queue block.
//
// Requests arrive on the req_ stream. tuser carries the operation: enqueue
// classifies tdata's value against three signed thresholds and appends it to
// one of four queues; dequeue pops the oldest value of the queue named in
// tdata. Every request yields exactly one response on the rsp_ stream, whose
// tuser carries the status (enqueued, dequeued, full or empty).
// Each queue takes at most DEPTH writes after reset; freed space is not reused.
// Thresholds are written through the csr_ port; the user must write them only
// while the block is idle, which the block itself does not enforce. A request
// passes through capture, execute (one RAM access plus counter update), and
// load into the response register, which is set by the registered read of the
// queue RAM. A new request is accepted only after the previous one has been
// loaded into the response register. A pending response does not block the
// next request; if the receiver stalls with one response waiting, the
// following request holds in the last step until the response register frees.
// Reset clears the queue counters and restores the thresholds to 10, 20, 30.
// Queue storage contents are not cleared; the counters keep unwritten
// entries from ever being read.
module range_classified_four_queues
   import rcfq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,  // value[15:0], queue_pick[17:16], zero pad
   input  logic [0:0]             req_tuser,  // operation[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,  // queue_used[1:0], data_out[17:2], zero pad
   output logic [1:0]             rsp_tuser,  // status[1:0]
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]     csr_wdata
);

   ctrl_cmd_type         cmd;
   dp_status_type        dp_status;
   logic [1:0]           rsp_status;
   logic [QUEUE_W-1:0]   rsp_queue;
   logic [VALUE_W-1:0]   rsp_data;

   rcfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   rcfq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_op        (req_tuser[0]),
      .req_value     (req_tdata[15:0]),
      .req_pick      (req_tdata[17:16]),
      .cmd           (cmd),
      .dp_status     (dp_status),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid_ff (rsp_tvalid),
      .rsp_status_ff (rsp_status),
      .rsp_queue_ff  (rsp_queue),
      .rsp_data_ff   (rsp_data)
   );

   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {6'd0, rsp_data, rsp_queue};

endmodule

FILE: tb/sv/rcfq_response_checker.sv
// Response checker for the range-classified four-queue block: predicts and compares responses.
module rcfq_response_checker
   import rcfq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [23:0]            req_tdata,   // value[15:0], queue_pick[17:16], zero pad
   input  logic [0:0]             req_tuser,   // operation[0]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [23:0]            rsp_tdata,   // queue_used[1:0], data_out[17:2], zero pad
   input  logic [1:0]             rsp_tuser,   // status[1:0]
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [VALUE_W-1:0]     csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type          status;
      logic [QUEUE_W-1:0]  queue_used;
      logic [VALUE_W-1:0]  data_out;
   } queue_reply_type;

   logic signed [VALUE_W-1:0] first_limit;
   logic signed [VALUE_W-1:0] second_limit;
   logic signed [VALUE_W-1:0] third_limit;
   logic [VALUE_W-1:0]        shadow_store [NUM_QUEUES][DEPTH];
   int                        writes_taken [NUM_QUEUES];
   int                        reads_served [NUM_QUEUES];
   queue_reply_type           awaited_replies [$];

   initial fail_count = 0;

   task automatic report_error(string msg);
      fail_count++;
      if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Applies one request to the shadow queues and returns the reply it should produce.
   function automatic queue_reply_type apply_queue_op(op_type op,
                                                      logic signed [VALUE_W-1:0] value,
                                                      logic [QUEUE_W-1:0] pick);
      queue_reply_type r;
      int              q;
      r.data_out = '0;
      if (op == OP_ENQUEUE) begin
         if (value < first_limit) q = 0;
         else if (value < second_limit) q = 1;
         else if (value < third_limit) q = 2;
         else q = 3;
         if (writes_taken[q] >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            shadow_store[q][writes_taken[q]] = value;
            writes_taken[q]++;
            r.status = STATUS_ENQUEUED;
         end
      end else begin
         q = pick;
         if (reads_served[q] >= writes_taken[q] || reads_served[q] >= DEPTH) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.data_out = shadow_store[q][reads_served[q]];
            reads_served[q]++;
            r.status = STATUS_DEQUEUED;
         end
      end
      r.queue_used = QUEUE_W'(q);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_reply_type want;
      queue_reply_type got;
      if (reset) begin
         first_limit  = FIRST_THRESHOLD_RESET;
         second_limit = SECOND_THRESHOLD_RESET;
         third_limit  = THIRD_THRESHOLD_RESET;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            writes_taken[i] = 0;
            reads_served[i] = 0;
         end
         awaited_replies.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_THRESHOLD:  first_limit  = csr_wdata;
               CSR_SECOND_THRESHOLD: second_limit = csr_wdata;
               CSR_THIRD_THRESHOLD:  third_limit  = csr_wdata;
               default: ;
            endcase
         end
         // Responses are retired before new requests, so a reply can never match a
         // request taken on the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tuser);
            got.queue_used = rsp_tdata[1:0];
            got.data_out   = rsp_tdata[17:2];
            if (awaited_replies.size() == 0) begin
               report_error($sformatf("response with nothing expected, status %0d queue %0d data %0d",
                                      got.status, got.queue_used, $signed(got.data_out)));
            end else begin
               want = awaited_replies.pop_front();
               if (got.status != want.status)
                  report_error($sformatf("status expected %0d got %0d",
                                         want.status, got.status));
               if (got.queue_used != want.queue_used)
                  report_error($sformatf("queue_used expected %0d got %0d",
                                         want.queue_used, got.queue_used));
               if (got.data_out != want.data_out)
                  report_error($sformatf("data_out expected %0d got %0d",
                                         $signed(want.data_out), $signed(got.data_out)));
            end
         end
         if (req_tvalid && req_tready)
            awaited_replies.push_back(apply_queue_op(op_type'(req_tuser[0]),
                                                     req_tdata[15:0], req_tdata[17:16]));
      end
      outstanding = awaited_replies.size();
   end

endmodule

FILE: tb/sv/range_classified_four_queues_tb.sv
// Top of the testbench: clock, reset, request and threshold stimulus, and the verdict.
module range_classified_four_queues_tb;
   import rcfq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_PHASES      = 7;
   localparam int ITEMS_PER_PHASE = 215;
   // Register index that maps to no threshold.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [23:0]            req_tdata;
   logic [0:0]             req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [23:0]            rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [VALUE_W-1:0]     csr_wdata;
   int                     fail_count;
   int                     outstanding;

   logic                   idle_enable;
   logic signed [VALUE_W-1:0] limit_copy [3];

   range_classified_four_queues dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rcfq_response_checker response_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_600_000;
      $display("Some tests failed");
      $finish;
   end

   // The receiver stalls on its own schedule, switched off during the calm stretch.
   always @(negedge clock) begin
      rsp_tready <= !idle_enable || ($urandom_range(99) >= 20);
   end

   task automatic send_request(op_type op, logic [VALUE_W-1:0] value, logic [QUEUE_W-1:0] pick);
      while (idle_enable && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, pick, value};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [VALUE_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index <= CSR_THIRD_THRESHOLD) limit_copy[index] = data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Values cluster around the thresholds so that every boundary is crossed often.
   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      int k;
      sel = $urandom_range(9);
      k   = $urandom_range(2);
      case (sel)
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2, 3, 4, 5: return VALUE_W'(limit_copy[k] + VALUE_W'($urandom_range(2)) - 16'd1);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [VALUE_W-1:0] t [3];
      logic [VALUE_W-1:0] swap;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      idle_enable = 1'b1;
      limit_copy[0] = FIRST_THRESHOLD_RESET;
      limit_copy[1] = SECOND_THRESHOLD_RESET;
      limit_copy[2] = THIRD_THRESHOLD_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every queue starts out never written, so each dequeue must report empty.
      for (int q = 0; q < NUM_QUEUES; q++)
         send_request(OP_DEQUEUE, VALUE_W'($urandom), QUEUE_W'(q));
      // Both sides of each reset threshold, plus the value extremes.
      send_request(OP_ENQUEUE, 16'h8000, QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'sd9,   QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'sd10,  QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'sd19,  QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'sd20,  QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'sd29,  QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'sd30,  QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'h7FFF, QUEUE_W'($urandom));
      send_request(OP_ENQUEUE, 16'sd100, QUEUE_W'($urandom));
      // Drain queue zero past its contents to hit empty after data.
      repeat (3) send_request(OP_DEQUEUE, VALUE_W'($urandom), 2'd0);
      for (int q = 1; q < NUM_QUEUES; q++)
         send_request(OP_DEQUEUE, VALUE_W'($urandom), QUEUE_W'(q));

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_idle();
         idle_enable = (p != 3);
         for (int i = 0; i < 3; i++) t[i] = VALUE_W'($urandom);
         case (p)
            0: write_csr(CSR_UNMAPPED, VALUE_W'($urandom));  // must change nothing
            1: begin
               t[0] = 16'h8000; t[1] = 16'h0000; t[2] = 16'h7FFF;
            end
            2: begin
               t[0] = 16'h7FFF; t[1] = 16'h7FFF; t[2] = 16'h7FFF;
            end
            3: begin
               // Thresholds out of order: the cascade still decides.
               t[0] = 16'sd100; t[1] = -16'sd100; t[2] = 16'sd0;
            end
            4: begin
               if ($signed(t[0]) > $signed(t[1])) begin swap = t[0]; t[0] = t[1]; t[1] = swap; end
               if ($signed(t[1]) > $signed(t[2])) begin swap = t[1]; t[1] = t[2]; t[2] = swap; end
               if ($signed(t[0]) > $signed(t[1])) begin swap = t[0]; t[0] = t[1]; t[1] = swap; end
            end
            6: begin
               t[0] = 16'h8000; t[1] = 16'h8000; t[2] = 16'h8000;
            end
            default: ;
         endcase
         if (p != 0) begin
            write_csr(CSR_FIRST_THRESHOLD,  t[0]);
            write_csr(CSR_SECOND_THRESHOLD, t[1]);
            write_csr(CSR_THIRD_THRESHOLD,  t[2]);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) < 60)
               send_request(OP_ENQUEUE, pick_value(), QUEUE_W'($urandom));
            else
               send_request(OP_DEQUEUE, VALUE_W'($urandom), QUEUE_W'($urandom));
         end
      end

      wait_for_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
